// ----- rtl/core/ffcs_pkg.sv -----
// Shared types and constants for the FIFO-fair counting semaphore.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ffcs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TICKET_BITS = 16;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CAP_W = 8;
  localparam int CMD_W = 2;
  localparam int CANCEL_W = 16;
  localparam int TK_OUT_W = 16;
  localparam int WAIT_OUT_W = 5;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 8'd4;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  typedef enum logic [2:0] {
    STS_GRANTED     = 3'd0,
    STS_QUEUED      = 3'd1,
    STS_REFUSED     = 3'd2,
    STS_CANCELLED   = 3'd3,
    STS_CANCEL_MISS = 3'd4,
    STS_RELEASED    = 3'd5,
    STS_REL_GRANT   = 3'd6,
    STS_REL_IGNORED = 3'd7
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/ffcs_ctrl.sv -----
// Controller state machine for the FIFO-fair counting semaphore.
// Depends on ffcs_pkg; drives load and execute commands into ffcs_dp.
`default_nettype none

module ffcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ffcs_pkg::dp_status_t dp_status,
  output ffcs_pkg::cmd_t      cmd
);
  import ffcs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!dp_status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec = !dp_status.out_busy;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ffcs_dp.sv -----
// Datapath of the FIFO-fair counting semaphore: shift-register wait queue,
// counters, capacity register and result register. Depends on ffcs_pkg.
`default_nettype none

module ffcs_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ffcs_pkg::cmd_t                  cmd,
  output ffcs_pkg::dp_status_t            dp_status,
  input  logic                            cfg_wr_en,
  input  logic [ffcs_pkg::CAP_W-1:0]      cfg_wr_data,
  input  logic [ffcs_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [ffcs_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ffcs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]                      out_tuser
);
  import ffcs_pkg::*;

  logic [CAP_W-1:0]       capacity_r;
  logic [CAP_W-1:0]       held_r, held_nxt;
  logic [TICKET_BITS-1:0] ticket_r, ticket_nxt;
  logic [CNT_W-1:0]       wc_r, wc_nxt;
  logic [TICKET_BITS-1:0] q_r   [QUEUE_DEPTH];
  logic [TICKET_BITS-1:0] q_nxt [QUEUE_DEPTH];

  logic [CMD_W-1:0]       cmd_r;
  logic [TICKET_BITS-1:0] want_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [2:0]             out_tuser_r;

  status_t                status;
  logic [TICKET_BITS-1:0] tk;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [IDX_W-1:0]       hit_idx;
  logic                   had;
  logic [CAP_W-1:0]       held_dec;

  assign dp_status.out_busy = out_valid_r && !out_tready;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit[i] = (CNT_W'(i) < wc_r) && (q_r[i] == want_r);
    end
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign had = held_r != '0;
  assign held_dec = had ? held_r - 8'd1 : held_r;

  always_comb begin
    status = STS_REL_IGNORED;
    tk = '0;
    held_nxt = held_r;
    ticket_nxt = ticket_r;
    wc_nxt = wc_r;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      q_nxt[j] = q_r[j];
    end
    case (cmd_r)
      CMD_ACQUIRE: begin
        if (capacity_r == '0) begin
          status = STS_REFUSED;
        end else if (held_r < capacity_r && wc_r == '0) begin
          status = STS_GRANTED;
          tk = ticket_r;
          ticket_nxt = ticket_r + 1'b1;
          held_nxt = held_r + 8'd1;
        end else if (wc_r < CNT_W'(QUEUE_DEPTH)) begin
          status = STS_QUEUED;
          tk = ticket_r;
          ticket_nxt = ticket_r + 1'b1;
          q_nxt[wc_r[IDX_W-1:0]] = ticket_r;
          wc_nxt = wc_r + 1'b1;
        end else begin
          status = STS_REFUSED;
        end
      end
      CMD_CANCEL: begin
        tk = want_r;
        if (|hit) begin
          status = STS_CANCELLED;
          for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            if (IDX_W'(j) >= hit_idx) begin
              q_nxt[j] = q_r[j+1];
            end
          end
          wc_nxt = wc_r - 1'b1;
        end else begin
          status = STS_CANCEL_MISS;
        end
      end
      CMD_RELEASE: begin
        held_nxt = held_dec;
        if (wc_r != '0 && held_dec < capacity_r) begin
          status = had ? STS_REL_GRANT : STS_GRANTED;
          tk = q_r[0];
          for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            q_nxt[j] = q_r[j+1];
          end
          wc_nxt = wc_r - 1'b1;
          held_nxt = held_dec + 8'd1;
        end else begin
          status = had ? STS_RELEASED : STS_REL_IGNORED;
        end
      end
      default: begin
        status = STS_REL_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      ticket_r <= '0;
      wc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        held_r <= held_nxt;
        ticket_r <= ticket_nxt;
        wc_r <= wc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_tuser;
      want_r <= TICKET_BITS'(in_tdata[CANCEL_W-1:0]);
    end
    if (cmd.exec) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        q_r[j] <= q_nxt[j];
      end
      out_tuser_r <= status;
      out_tdata_r <= {3'b000, WAIT_OUT_W'(wc_nxt), held_nxt, TK_OUT_W'(tk)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= CNT_W'(QUEUE_DEPTH))
    else $error("wait count exceeds queue depth");

  a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && !out_tready))
    else $error("result overwritten while stalled");

  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed item produced no result");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(held_r) && $stable(wc_r) && $stable(ticket_r))
    else $error("state changed without an executed item");

endmodule

`default_nettype wire

// ----- rtl/core/fifo_fair_counting_semaphore.sv -----
// Top level of the FIFO-fair counting semaphore with tickets.
// Instantiates ffcs_ctrl and ffcs_dp; depends on ffcs_pkg.
//
// Usage: each input beat carries a command in in_tuser (acquire, cancel,
// release) and, for cancel, the ticket to withdraw in in_tdata. Every beat
// yields exactly one output beat: the status code in out_tuser and the
// ticket, slots in use and waiter count in out_tdata.
// The capacity register is written with cfg_wr_en and cfg_wr_data; the user
// must write it only while idle; the block itself does not enforce this.
// A beat accepted in the idle state is loaded; the controller takes no other
// beat until it executes, once the result register is free; out_tvalid then
// shows the result. The wait queue is a shift register compared in parallel.
// Reset: slots held, ticket counter and waiters clear; capacity returns to 4.
// Stall: the result register holds while out_tready is low; a further item is
// accepted meanwhile, but its execution waits until the result is taken.
`default_nettype none

module fifo_fair_counting_semaphore (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cancel_ticket[15:0]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // ticket_out[15:0], slots_in_use[23:16],
                                  // waiters_now[28:24], zero pad[31:29]
  output logic [2:0]  out_tuser   // status[2:0]
);
  import ffcs_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  ffcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  ffcs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .dp_status   (dp_status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

// ----- test/fifo_fair_counting_semaphore_test.sv -----
// Testbench for fifo_fair_counting_semaphore: drives command beats, predicts every result
// with its own ticket and wait-queue copy, and compares each output beat field by field.
// Depends on ffcs_pkg and the fifo_fair_counting_semaphore RTL.
`timescale 1ns / 100ps

module fifo_fair_counting_semaphore_test;
  import ffcs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 200;

  typedef struct packed {
    status_t status;
    logic [15:0] ticket;
    logic [7:0] slots;
    logic [4:0] waiters;
  } sem_report_t;

  class ffcs_scoreboard;
    logic [7:0] capacity;
    logic [7:0] held;
    logic [15:0] next_ticket;
    logic [15:0] waiting[$];
    sem_report_t pending[$];
    int errors;

    function new();
      capacity = CAPACITY_RESET;
      held = '0;
      next_ticket = '0;
      errors = 0;
    endfunction

    function void note_input(logic [1:0] cmd, logic [15:0] want);
      status_t st;
      logic [15:0] tk;
      int idx;
      logic had;
      sem_report_t rep;
      st = STS_REL_IGNORED;
      tk = '0;
      idx = -1;
      case (cmd)
        CMD_ACQUIRE: begin
          if (capacity == 0) begin
            st = STS_REFUSED;
          end else if (held < capacity && waiting.size() == 0) begin
            st = STS_GRANTED;
            tk = next_ticket;
            next_ticket = next_ticket + 1'b1;
            held = held + 1'b1;
          end else if (waiting.size() < QUEUE_DEPTH) begin
            st = STS_QUEUED;
            tk = next_ticket;
            next_ticket = next_ticket + 1'b1;
            waiting = {waiting, tk};
          end else begin
            st = STS_REFUSED;
          end
        end
        CMD_CANCEL: begin
          tk = want;
          for (int i = 0; i < waiting.size() && idx < 0; i++) begin
            if (waiting[i] == want) idx = i;
          end
          if (idx >= 0) begin
            waiting.delete(idx);
            st = STS_CANCELLED;
          end else begin
            st = STS_CANCEL_MISS;
          end
        end
        CMD_RELEASE: begin
          had = (held != 0);
          if (had) held = held - 1'b1;
          if (waiting.size() > 0 && held < capacity) begin
            tk = waiting[0];
            waiting.delete(0);
            held = held + 1'b1;
            st = had ? STS_REL_GRANT : STS_GRANTED;
          end else begin
            st = had ? STS_RELEASED : STS_REL_IGNORED;
          end
        end
        default: begin
          st = STS_REL_IGNORED;
        end
      endcase
      rep.status = st;
      rep.ticket = tk;
      rep.slots = held;
      rep.waiters = 5'(waiting.size());
      pending = {pending, rep};
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] data);
      sem_report_t exp;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %0d data %h", $time, st, data);
        errors++;
      end else begin
        exp = pending[0];
        pending.delete(0);
        if (exp.status != status_t'(st)) begin
          $display("%0t: status expected %0d, got %0d", $time, exp.status, st);
          errors++;
        end
        if (exp.ticket != data[15:0]) begin
          $display("%0t: ticket expected %0d, got %0d", $time, exp.ticket, data[15:0]);
          errors++;
        end
        if (exp.slots != data[23:16]) begin
          $display("%0t: slots in use expected %0d, got %0d", $time, exp.slots, data[23:16]);
          errors++;
        end
        if (exp.waiters != data[28:24]) begin
          $display("%0t: waiters expected %0d, got %0d", $time, exp.waiters, data[28:24]);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  ffcs_scoreboard sb;
  logic in_fire;
  int send_idle_pct;
  int recv_idle_pct;
  logic pressure_armed;
  int stall_cycles;

  fifo_fair_counting_semaphore dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Signals are stable between the falling edge and the next rising edge, so a
  // beat seen here is the one accepted at the coming rising edge.
  always @(negedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata);
      stall_cycles = 0;
    end else if (in_fire) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (in_fire) sb.note_input(in_tuser, in_tdata);
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin : receiver
    static int hold_left = 0;
    static logic hold_done = 1'b0;
    if (pressure_armed && !hold_done) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] ticket);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= ticket;
    @(posedge clk);
    while (!in_fire) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [7:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.capacity = value;
  endtask

  task automatic run_random(input int count, input int acq_pct, input int rel_pct,
                            input int cancel_pct);
    int r;
    logic [15:0] t;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      t = 16'($urandom);
      if (r < acq_pct) begin
        send_item(CMD_ACQUIRE, t);
      end else if (r < acq_pct + rel_pct) begin
        send_item(CMD_RELEASE, t);
      end else if (r < acq_pct + rel_pct + cancel_pct) begin
        if (sb.waiting.size() > 0 && $urandom_range(9) < 7)
          t = sb.waiting[$urandom_range(sb.waiting.size() - 1)];
        send_item(CMD_CANCEL, t);
      end else begin
        send_item(CMD_UNUSED, t);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_ACQUIRE;
    out_tready = 1'b0;
    in_fire = 1'b0;
    stall_cycles = 0;
    pressure_armed = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 59;
    send_item(CMD_RELEASE, 16'h0000);
    send_item(CMD_UNUSED, 16'hFFFF);
    repeat (4) send_item(CMD_ACQUIRE, 16'h0000);
    send_item(CMD_ACQUIRE, 16'hFFFF);
    send_item(CMD_ACQUIRE, 16'h0000);
    send_item(CMD_CANCEL, 16'hFFFF);
    send_item(CMD_CANCEL, 16'd4);
    send_item(CMD_RELEASE, 16'hFFFF);
    send_item(CMD_CANCEL, 16'd0);
    repeat (4) send_item(CMD_RELEASE, 16'h0000);
    send_item(CMD_RELEASE, 16'h0000);
    write_capacity(8'd0);
    send_item(CMD_ACQUIRE, 16'h0000);
    write_capacity(8'd1);
    send_item(CMD_ACQUIRE, 16'h0000);
    send_item(CMD_ACQUIRE, 16'h0000);
    write_capacity(8'd0);
    send_item(CMD_RELEASE, 16'h0000);
    write_capacity(8'd1);
    send_item(CMD_RELEASE, 16'h0000);
    send_item(CMD_RELEASE, 16'h0000);

    write_capacity(8'd1);
    run_random(130, 45, 35, 15);
    write_capacity(8'd0);
    run_random(40, 40, 40, 15);

    send_idle_pct = 59;
    recv_idle_pct = 17;
    write_capacity(8'd255);
    run_random(300, 93, 4, 2);
    write_capacity(8'd3);
    run_random(130, 40, 35, 20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(8'($urandom_range(8, 2)));
    pressure_armed = 1'b1;
    run_random(130, 50, 30, 15);
    write_capacity(8'd4);
    run_random(80, 40, 35, 20);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ffcs_pkg.sv
rtl/core/ffcs_ctrl.sv
rtl/core/ffcs_dp.sv
rtl/core/fifo_fair_counting_semaphore.sv
test/fifo_fair_counting_semaphore_test.sv
